### rtl/whole_word_matcher_macros.svh
// Assertion helpers for the file that checks its own logic (whole_word_matcher.sv).
`ifndef WHOLE_WORD_MATCHER_MACROS_SVH
`define WHOLE_WORD_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("whole_word_matcher: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("whole_word_matcher: next-cycle check failed");

`endif

### rtl/wwm_pkg.sv
`default_nettype none

package wwm_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 64;
    localparam int LEN_W  = 5;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 8;

    localparam int DEF_MAX_WORD    = 16;
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Pattern storage holds sixteen bytes; longer words see zero bytes.
    localparam int PATTERN_BYTES = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

`default_nettype wire

### rtl/wwm_front.sv
`default_nettype none

module wwm_front #(
    parameter int MAX_WORD    = 16,
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [wwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wwm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_valid,
    input  wire logic [wwm_pkg::BYTE_W-1:0]     i_text_byte,
    input  wire logic                           i_row_end,
    input  wire logic                           i_full,
    output wwm_pkg::t_push                      o_push
);
    import wwm_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CFG_W-1:0]  r_pat_low;
    logic [CFG_W-1:0]  r_pat_high;
    logic [LEN_W-1:0]  r_pat_len;

    logic [BYTE_W-1:0] r_recent [MAX_WORD+1];
    logic [BYTE_W-1:0] n_recent [MAX_WORD+1];
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;

    logic [2*CFG_W-1:0] pat_all;
    logic [BYTE_W-1:0]  pat [MAX_WORD];

    logic [LW-1:0]     len;
    logic              word_eq;
    logic [BYTE_W-1:0] aligned;
    logic [BYTE_W-1:0] before_byte;
    logic              col_ge;
    logic              cols_full;
    logic [CW-1:0]     start;
    logic              follow_letter;
    logic              hit;
    logic              accept;

    assign pat_all = {r_pat_high, r_pat_low};

    for (genvar g = 0; g < MAX_WORD; g++) begin : g_pat
        if (g < PATTERN_BYTES) begin : g_stored
            assign pat[g] = pat_all[BYTE_W*g +: BYTE_W];
        end else begin : g_zero
            assign pat[g] = '0;
        end
    end

    always_comb begin
        if (r_pat_len == '0) begin
            len = LW'(1);
        end else if (32'(r_pat_len) > MAX_WORD) begin
            len = LW'(MAX_WORD);
        end else begin
            len = LW'(r_pat_len);
        end

        // Stored byte j lines up with pattern byte len-1-j.
        word_eq = 1'b1;
        for (int j = 0; j < MAX_WORD; j++) begin
            aligned = '0;
            for (int k = 0; k < MAX_WORD; k++) begin
                if (j + k + 1 == int'(len)) begin
                    aligned = pat[k];
                end
            end
            if ((j < int'(len)) && (r_recent[j] != aligned)) begin
                word_eq = 1'b0;
            end
        end

        before_byte = '0;
        for (int j = 0; j <= MAX_WORD; j++) begin
            if (j == int'(len)) begin
                before_byte = r_recent[j];
            end
        end

        col_ge        = (32'(r_col) >= 32'(len));
        cols_full     = (32'(r_col) >= MAX_COLUMNS);
        // Only meaningful when col_ge holds, and then len fits the column width.
        start         = r_col - CW'(len);
        follow_letter = !i_row_end && is_letter(i_text_byte);
        hit           = col_ge && word_eq && !follow_letter
                        && !((start != '0) && is_letter(before_byte));

        accept = i_valid && !i_full;

        o_push.valid       = accept && (i_row_end || !cols_full) && hit;
        o_push.data.row    = ROW_W'(r_row);
        o_push.data.column = COL_W'(start);

        n_recent = r_recent;
        n_col    = r_col;
        n_row    = r_row;
        if (accept) begin
            if (i_row_end) begin
                for (int i = 0; i <= MAX_WORD; i++) begin
                    n_recent[i] = '0;
                end
                n_col = '0;
                if (32'(r_row) < MAX_ROWS - 1) begin
                    n_row = r_row + 1'b1;
                end
            end else if (!cols_full) begin
                for (int i = MAX_WORD; i > 0; i--) begin
                    n_recent[i] = r_recent[i-1];
                end
                n_recent[0] = i_text_byte;
                n_col       = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
            for (int i = 0; i <= MAX_WORD; i++) begin
                r_recent[i] <= '0;
            end
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                    REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                    REG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_recent <= n_recent;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

`default_nettype wire

### rtl/wwm_queue.sv
`default_nettype none

module wwm_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wwm_pkg::t_push   i_push,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output wwm_pkg::t_result      o_head
);
    import wwm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [NW-1:0]  r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (32'(r_count) == DEPTH);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        do_push = i_push.valid && !o_full;
        do_pop  = i_pop && !o_empty;

        n_wr = r_wr;
        if (do_push) begin
            n_wr = (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + 1'b1;
        end
        n_rd = r_rd;
        if (do_pop) begin
            n_rd = (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + 1'b1;
        end

        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/wwm_back.sv
`default_nettype none

module wwm_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    input  wire wwm_pkg::t_result           i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [wwm_pkg::ROW_W-1:0]       o_match_row,
    output logic [wwm_pkg::COL_W-1:0]       o_match_column
);
    import wwm_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    // The output register takes a queued result when empty or its transaction completes.
    always_comb begin
        o_pop   = !i_empty && (!r_valid || !i_stall);
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_match_row    = r_data.row;
    assign o_match_column = r_data.column;

endmodule

`default_nettype wire

### rtl/whole_word_matcher.sv
// Whole-word matcher: one text byte or row end accepted per cycle while the input is not stalled.
// A match is written into the result queue at the accepting edge and moves into the
// output register once that register is empty or its result has been taken.
// The input stalls only while the result queue is full.
// Reset (synchronous, active low) empties the queue and output register and
// clears the row, column and recent-byte state; pattern registers take defaults.
`default_nettype none

module whole_word_matcher #(
    parameter int MAX_WORD    = wwm_pkg::DEF_MAX_WORD,
    parameter int MAX_COLUMNS = wwm_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = wwm_pkg::DEF_MAX_ROWS,
    parameter int QUEUE_DEPTH = wwm_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [wwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wwm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [wwm_pkg::BYTE_W-1:0]     i_text_byte,
    input  wire logic                           i_row_end,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [wwm_pkg::ROW_W-1:0]           o_match_row,
    output logic [wwm_pkg::COL_W-1:0]           o_match_column
);
    import wwm_pkg::*;

    t_push   push;
    t_result q_head;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    assign o_in_stall = q_full;

    wwm_front #(
        .MAX_WORD    (MAX_WORD),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .i_text_byte (i_text_byte),
        .i_row_end   (i_row_end),
        .i_full      (q_full),
        .o_push      (push)
    );

    wwm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    wwm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_match_row    (o_match_row),
        .o_match_column (o_match_column)
    );

`include "whole_word_matcher_macros.svh"

    `WWM_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, push.valid, !q_full)
    `WWM_ASSERT_NEXT(a_queued_result_shown, i_clk, i_rst_n, !q_empty && !o_out_valid, o_out_valid)
    `WWM_ASSERT_NEXT(a_no_result_from_empty, i_clk, i_rst_n, q_empty && !o_out_valid, !o_out_valid)

endmodule

`default_nettype wire

### tb/sv/whole_word_matcher_tb.sv
`default_nettype none

module whole_word_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wwm_pkg::*;

    localparam int WORD_MAX      = DEF_MAX_WORD;
    localparam int COLUMNS_MAX   = DEF_MAX_COLUMNS;
    localparam int ROWS_MAX      = DEF_MAX_ROWS;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 4000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]    i_text_byte = '0;
    logic                 i_row_end   = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [ROW_W-1:0]     o_match_row;
    logic [COL_W-1:0]     o_match_column;

    // Model of the matcher: configuration, recent bytes of the row and counters.
    logic [CFG_W-1:0]  pat_low  = '0;
    logic [CFG_W-1:0]  pat_high = '0;
    logic [LEN_W-1:0]  pat_len  = 5'd1;
    logic [BYTE_W-1:0] window [0:WORD_MAX];
    int                col_count = 0;
    int                row_index = 0;
    t_result           expected_hits [$];

    int          error_count  = 0;
    int          quiet_cycles = 0;
    int          sent_items   = 0;
    int          burst_left   = 0;
    int          gap_max      = 0;
    int          burst_max    = 1;
    int          stall_tick   = 0;
    t_stall_mode stall_mode   = STALL_NONE;

    whole_word_matcher u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_row_end      (i_row_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_match_row    (o_match_row),
        .o_match_column (o_match_column)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit letter_byte(input logic [BYTE_W-1:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic int used_length();
        if (pat_len == 0) begin
            return 1;
        end
        return (pat_len > WORD_MAX) ? WORD_MAX : int'(pat_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(input int k);
        if (k < 8) begin
            return pat_low[8*k +: 8];
        end else if (k < PATTERN_BYTES) begin
            return pat_high[8*(k-8) +: 8];
        end
        return 8'h00;
    endfunction

    // The candidate ends with the newest stored byte; the item after it decides.
    function automatic void check_word(input bit next_letter);
        int len;
        int start;
        bit hit;
        len = used_length();
        hit = !next_letter && (col_count >= len);
        for (int k = 0; k < len; k++) begin
            if (window[len-1-k] != pat_byte(k)) begin
                hit = 1'b0;
            end
        end
        start = col_count - len;
        if (hit && start > 0 && letter_byte(window[len])) begin
            hit = 1'b0;
        end
        if (hit) begin
            expected_hits.push_back('{row: row_index[ROW_W-1:0], column: start[COL_W-1:0]});
        end
    endfunction

    function automatic void predict_item(input logic [BYTE_W-1:0] b, input logic end_flag);
        if (end_flag) begin
            check_word(1'b0);
            for (int i = 0; i <= WORD_MAX; i++) begin
                window[i] = 8'h00;
            end
            col_count = 0;
            if (row_index < ROWS_MAX - 1) begin
                row_index++;
            end
        end else if (col_count < COLUMNS_MAX) begin
            check_word(letter_byte(b));
            for (int i = WORD_MAX; i > 0; i--) begin
                window[i] = window[i-1];
            end
            window[0] = b;
            col_count++;
        end
    endfunction

    function automatic void note_error(input string text);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s", $realtime, text);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] any_letter();
        return ($urandom_range(0, 1) == 0) ? BYTE_W'(8'h61 + $urandom_range(0, 25))
                                           : BYTE_W'(8'h41 + $urandom_range(0, 25));
    endfunction

    function automatic logic [BYTE_W-1:0] any_non_letter();
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom_range(0, 255));
        end while (letter_byte(b));
        return b;
    endfunction

    // Result checking, prediction of accepted transactions and the watchdog.
    always @(posedge i_clk) begin : monitor_blk
        t_result want;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_hits.size() == 0) begin
                    note_error($sformatf("unexpected match: row %0d column %0d",
                                         o_match_row, o_match_column));
                end else begin
                    want = expected_hits.pop_front();
                    if (want.row !== o_match_row || want.column !== o_match_column) begin
                        note_error($sformatf({"match mismatch: expected row %0d column %0d,",
                                              " got row %0d column %0d"},
                                             want.row, want.column,
                                             o_match_row, o_match_column));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                predict_item(i_text_byte, i_row_end);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_out_stall <= ((stall_tick % 11) < 6);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    task automatic send_char(input logic [BYTE_W-1:0] b, input logic end_flag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_row_end   <= end_flag;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
    endtask

    task automatic end_row();
        send_char(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0);
        end
    endtask

    task automatic send_word(input int n);
        for (int k = 0; k < n; k++) begin
            send_char(pat_byte(k), 1'b0);
        end
    endtask

    // Holds the sender back until every expected match has been delivered.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_PATTERN_LOW:    pat_low  = data;
            REG_PATTERN_HIGH:   pat_high = data;
            REG_PATTERN_LENGTH: pat_len  = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input int len_value);
        logic [CFG_W-1:0] len_data;
        settle();
        // Upper bits of the length write carry noise; only the low five count.
        len_data = {$urandom, $urandom};
        len_data[LEN_W-1:0] = len_value[LEN_W-1:0];
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, len_data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_word(input string w, input int len_value);
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        lo = '0;
        hi = '0;
        for (int i = 0; i < w.len(); i++) begin
            if (i < 8) begin
                lo[8*i +: 8] = w[i];
            end else begin
                hi[8*(i-8) +: 8] = w[i];
            end
        end
        write_config(lo, hi, len_value);
    endtask

    task automatic set_pace(input t_stall_mode mode, input int gaps, input int bursts);
        stall_mode = mode;
        gap_max    = gaps;
        burst_max  = bursts;
    endtask

    // The pattern after reset is a single zero byte.
    task automatic test_reset_pattern();
        set_pace(STALL_LIGHT, 3, 4);
        send_char(8'h00, 1'b0);
        send_char("A", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(" ", 1'b0);
        send_char(8'h00, 1'b0);
        end_row();
    endtask

    task automatic test_word_boundaries();
        set_pace(STALL_HEAVY, 2, 3);
        set_word("cat", 3);
        send_text("cat");
        end_row();
        send_text("concat cats,cat");
        end_row();
        send_text("Cat cat9");
        end_row();
    endtask

    task automatic test_length_limits();
        set_pace(STALL_PERIODIC, 2, 5);
        // A length of zero behaves as a length of one.
        write_config(64'h7A, 64'h0, 0);
        send_text("z zz z");
        end_row();
        // Lengths above the word limit use sixteen bytes.
        write_config(64'h7A61_5A41_FF00_7F80, 64'h0123_4567_89AB_CDEF, 31);
        send_char("#", 1'b0);
        send_word(16);
        end_row();
        send_char("x", 1'b0);
        send_word(16);
        send_char("!", 1'b0);
        end_row();
        write_config('1, '1, 16);
        repeat (17) send_char(8'hFF, 1'b0);
        end_row();
        write_config('0, '0, 16);
        repeat (16) send_char(8'h00, 1'b0);
        end_row();
    endtask

    // Characters past the column limit are dropped, so the row end follows directly.
    task automatic test_long_rows();
        set_pace(STALL_LIGHT, 0, 1);
        set_word("ab", 2);
        repeat (254) send_char(" ", 1'b0);
        send_text("ab");
        repeat (6) send_char("q", 1'b0);
        end_row();
        set_word("Q", 1);
        repeat (255) send_char("0", 1'b0);
        send_text("QZ");
        end_row();
    endtask

    task automatic random_pattern();
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [BYTE_W-1:0] b;
        int pick;
        int len_value;
        lo = '0;
        hi = '0;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            b = ($urandom_range(0, 9) < 7) ? any_letter() : any_non_letter();
            if (k < 8) begin
                lo[8*k +: 8] = b;
            end else begin
                hi[8*(k-8) +: 8] = b;
            end
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0:       len_value = 0;
            1:       len_value = $urandom_range(17, 31);
            2:       len_value = 16;
            default: len_value = $urandom_range(1, 6);
        endcase
        write_config(lo, hi, len_value);
    endtask

    // Rows of separated tokens: mostly the pattern, some glued to letters or cut short.
    task automatic random_row();
        int tokens;
        int pick;
        int len;
        len = used_length();
        if ($urandom_range(0, 19) == 0) begin
            end_row();
            return;
        end
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 2)) send_char(any_non_letter(), 1'b0);
            end
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: send_word(len);
                4: begin
                    send_char(any_letter(), 1'b0);
                    send_word(len);
                end
                5: begin
                    send_word(len);
                    send_char(any_letter(), 1'b0);
                end
                6: send_word($urandom_range(0, len - 1));
                7: repeat ($urandom_range(1, 5)) send_char(any_letter(), 1'b0);
                default: repeat ($urandom_range(1, 4))
                    send_char(BYTE_W'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        end_row();
    endtask

    task automatic random_phase(input t_stall_mode mode, input int gaps, input int bursts,
                                input int n_items);
        int target;
        int half;
        bit paused;
        set_pace(mode, gaps, bursts);
        random_pattern();
        target = sent_items + n_items;
        half   = sent_items + n_items / 2;
        paused = 1'b0;
        while (sent_items < target) begin
            random_row();
            if (!paused && sent_items >= half) begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_random_text();
        random_phase(STALL_NONE, 0, 1, 100);
        random_phase(STALL_LIGHT, 6, 8, 100);
        random_phase(STALL_HEAVY, 3, 4, 100);
        random_phase(STALL_PERIODIC, 0, 1, 100);
        random_phase(STALL_LIGHT, 12, 20, 100);
    endtask

    // Enough rows to pass the row limit; later rows all report the last index.
    task automatic test_row_saturation();
        int rows_left;
        set_pace(STALL_LIGHT, 2, 10);
        set_word("ok", 2);
        rows_left = ROWS_MAX + 4 - row_index;
        for (int r = 0; r < rows_left; r++) begin
            if (r % 97 == 0 || r >= rows_left - 8) begin
                send_text("ok");
            end
            end_row();
        end
    endtask

    initial begin
        for (int i = 0; i <= WORD_MAX; i++) begin
            window[i] = 8'h00;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_pattern();
        test_word_boundaries();
        test_length_limits();
        test_long_rows();
        test_random_text();
        test_row_saturation();
        settle();

        error_count += expected_hits.size();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
